### rtl/jtn_pkg.sv
`default_nettype none

package jtn_pkg;

  // Ones given from the unknown state to reach Test-Logic-Reset
  localparam int unsigned RESET_PULSES = 5;
  localparam int unsigned RstCntW      = $clog2(RESET_PULSES);

  // Believed TAP state: 4-bit TAP code plus an unknown flag in bit 4
  localparam int unsigned TapW = 5;

  localparam logic [3:0] TAP_RESET    = 4'd0;
  localparam logic [3:0] TAP_IDLE     = 4'd1;
  localparam logic [3:0] TAP_SEL_DR   = 4'd2;
  localparam logic [3:0] TAP_CAP_DR   = 4'd3;
  localparam logic [3:0] TAP_SHIFT_DR = 4'd4;
  localparam logic [3:0] TAP_EXIT1_DR = 4'd5;
  localparam logic [3:0] TAP_PAUSE_DR = 4'd6;
  localparam logic [3:0] TAP_EXIT2_DR = 4'd7;
  localparam logic [3:0] TAP_UPD_DR   = 4'd8;
  localparam logic [3:0] TAP_SEL_IR   = 4'd9;
  localparam logic [3:0] TAP_CAP_IR   = 4'd10;
  localparam logic [3:0] TAP_SHIFT_IR = 4'd11;
  localparam logic [3:0] TAP_EXIT1_IR = 4'd12;
  localparam logic [3:0] TAP_PAUSE_IR = 4'd13;
  localparam logic [3:0] TAP_EXIT2_IR = 4'd14;
  localparam logic [3:0] TAP_UPD_IR   = 4'd15;

  localparam logic [TapW-1:0] TAP_UNKNOWN = 5'd16;

  // Input kinds carried in tuser
  localparam logic OP_NAVIGATE = 1'b0;
  localparam logic OP_FORGET   = 1'b1;

  typedef struct packed {
    logic       tms;
    logic [3:0] nxt;
  } tap_step_t;

  // One TCK pulse of the walk: TMS level and next state toward target t
  function automatic tap_step_t tap_step(input logic [3:0] s, input logic [3:0] t);
    tap_step_t r;
    r.tms = 1'b0;
    r.nxt = TAP_IDLE;
    case (s)
      TAP_RESET: begin
        r.tms = 1'b0; r.nxt = TAP_IDLE;
      end
      TAP_IDLE: begin
        r.tms = 1'b1; r.nxt = TAP_SEL_DR;
      end
      TAP_SEL_DR: begin
        if (t >= TAP_SEL_IR || t == TAP_RESET) begin
          r.tms = 1'b1; r.nxt = TAP_SEL_IR;
        end else begin
          r.tms = 1'b0; r.nxt = TAP_CAP_DR;
        end
      end
      TAP_SEL_IR: begin
        if (t < TAP_SEL_IR) begin
          r.tms = 1'b1; r.nxt = TAP_RESET;
        end else begin
          r.tms = 1'b0; r.nxt = TAP_CAP_IR;
        end
      end
      TAP_UPD_DR: begin
        if (t == TAP_SEL_DR) begin
          r.tms = 1'b1; r.nxt = TAP_SEL_DR;
        end else begin
          r.tms = 1'b0; r.nxt = TAP_IDLE;
        end
      end
      TAP_UPD_IR: begin
        if (t == TAP_SEL_IR) begin
          r.tms = 1'b1; r.nxt = TAP_SEL_DR;
        end else begin
          r.tms = 1'b0; r.nxt = TAP_IDLE;
        end
      end
      TAP_CAP_DR: begin
        if (t >= TAP_EXIT1_DR) begin
          r.tms = 1'b1; r.nxt = TAP_EXIT1_DR;
        end else begin
          r.tms = 1'b0; r.nxt = TAP_SHIFT_DR;
        end
      end
      TAP_CAP_IR: begin
        if (t >= TAP_EXIT1_IR) begin
          r.tms = 1'b1; r.nxt = TAP_EXIT1_IR;
        end else begin
          r.tms = 1'b0; r.nxt = TAP_SHIFT_IR;
        end
      end
      TAP_SHIFT_DR: begin
        r.tms = 1'b1; r.nxt = TAP_EXIT1_DR;
      end
      TAP_SHIFT_IR: begin
        r.tms = 1'b1; r.nxt = TAP_EXIT1_IR;
      end
      TAP_EXIT1_DR: begin
        if (t == TAP_PAUSE_DR || t == TAP_EXIT2_DR) begin
          r.tms = 1'b0; r.nxt = TAP_PAUSE_DR;
        end else begin
          r.tms = 1'b1; r.nxt = TAP_UPD_DR;
        end
      end
      TAP_EXIT1_IR: begin
        if (t == TAP_PAUSE_IR || t == TAP_EXIT2_IR) begin
          r.tms = 1'b0; r.nxt = TAP_PAUSE_IR;
        end else begin
          r.tms = 1'b1; r.nxt = TAP_UPD_IR;
        end
      end
      TAP_PAUSE_DR: begin
        r.tms = 1'b1; r.nxt = TAP_EXIT2_DR;
      end
      TAP_PAUSE_IR: begin
        r.tms = 1'b1; r.nxt = TAP_EXIT2_IR;
      end
      TAP_EXIT2_DR: begin
        if (t == TAP_SHIFT_DR) begin
          r.tms = 1'b0; r.nxt = TAP_SHIFT_DR;
        end else begin
          r.tms = 1'b1; r.nxt = TAP_UPD_DR;
        end
      end
      TAP_EXIT2_IR: begin
        if (t == TAP_SHIFT_IR) begin
          r.tms = 1'b0; r.nxt = TAP_SHIFT_IR;
        end else begin
          r.tms = 1'b1; r.nxt = TAP_UPD_IR;
        end
      end
      default: begin
        r.tms = 1'b0; r.nxt = TAP_IDLE;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/jtag_tap_navigator_unit.sv
// JTAG TAP walker. Keeps the believed TAP state and turns a request into a
// run of TMS bits, one output beat per TCK pulse.
// Input channel (s_axis): tuser = op (navigate or forget), tdata[3:0] = target
// TAP state. Output channel (m_axis): tdata[0] = TMS level, tlast marks the
// pulse that lands on the target state.
// A navigate beat walks the standard 16-state TAP graph; from the unknown
// state it first gives RESET_PULSES ones to reach Test-Logic-Reset. A walk
// gives 0 to RESET_PULSES + 7 beats (12 at five reset pulses). A forget beat,
// or a navigate beat for the state already held, gives no beats.
// Timing: a navigate beat taken while idle starts the walk, and each TMS beat
// is registered in the output register; beats follow one per cycle while the
// receiver takes them, computed by one next-state unit stepped by the walk
// sequencer. tready stays low during a walk, so the next item is taken once
// the last beat is registered; an item with no beats leaves tready high.
// The output register lets the next input beat be taken while the last TMS
// beat still waits. When the receiver stalls, the walk pauses and the held
// beat stays stable.
// Reset clears the channels and marks the TAP state unknown.
`default_nettype none

module jtag_tap_navigator_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input beats
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [3:0] target_state, [7:4] zero
  input  wire logic       s_axis_tuser_i,   // [0] op
  // TMS beats
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [0] tms, [7:1] zero
  output logic            m_axis_tlast_o    // last
);

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_WALK = 2'b10
  } seq_state_e;

  seq_state_e                    seq_q, seq_d;
  logic [jtn_pkg::TapW-1:0]      tap_q, tap_d;
  logic [jtn_pkg::RstCntW-1:0]   rst_cnt_q, rst_cnt_d;
  logic [3:0]                    target_q, target_d;
  logic                          out_vld_q, out_vld_d;
  logic                          out_tms_q, out_tms_d;
  logic                          out_last_q, out_last_d;

  logic                          in_acc;
  logic                          slot_free;
  logic                          step_en;
  logic                          unknown;
  logic                          rst_done;
  logic                          emit_tms;
  logic                          emit_last;
  jtn_pkg::tap_step_t            step;

  assign s_axis_tready_o = (seq_q == SEQ_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !out_vld_q || m_axis_tready_i;
  assign step_en         = (seq_q == SEQ_WALK) && slot_free;

  // Shared next-state unit, stepped once per TCK pulse
  assign unknown  = tap_q[jtn_pkg::TapW-1];
  assign step     = jtn_pkg::tap_step(tap_q[3:0], target_q);
  assign rst_done = (rst_cnt_q == jtn_pkg::RstCntW'(jtn_pkg::RESET_PULSES - 1));

  always_comb begin
    if (unknown) begin
      emit_tms  = 1'b1;
      emit_last = rst_done && (target_q == jtn_pkg::TAP_RESET);
    end else begin
      emit_tms  = step.tms;
      emit_last = (step.nxt == target_q);
    end
  end

  // Sequencer: take a request, then walk one pulse per free output slot
  always_comb begin
    seq_d      = seq_q;
    tap_d      = tap_q;
    rst_cnt_d  = rst_cnt_q;
    target_d   = target_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_tms_d  = out_tms_q;
    out_last_d = out_last_q;
    case (seq_q)
      SEQ_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == jtn_pkg::OP_FORGET) begin
            tap_d     = jtn_pkg::TAP_UNKNOWN;
            rst_cnt_d = '0;
          end else if (tap_q != {1'b0, s_axis_tdata_i[3:0]}) begin
            target_d = s_axis_tdata_i[3:0];
            seq_d    = SEQ_WALK;
          end
        end
      end
      SEQ_WALK: begin
        if (step_en) begin
          out_vld_d  = 1'b1;
          out_tms_d  = emit_tms;
          out_last_d = emit_last;
          if (unknown) begin
            if (rst_done) begin
              tap_d     = {1'b0, jtn_pkg::TAP_RESET};
              rst_cnt_d = '0;
            end else begin
              rst_cnt_d = rst_cnt_q + 1'b1;
            end
          end else begin
            tap_d = {1'b0, step.nxt};
          end
          if (emit_last) begin
            seq_d = SEQ_IDLE;
          end
        end
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= SEQ_IDLE;
      tap_q     <= jtn_pkg::TAP_UNKNOWN;
      rst_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      seq_q     <= seq_d;
      tap_q     <= tap_d;
      rst_cnt_q <= rst_cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    target_q   <= target_d;
    out_tms_q  <= out_tms_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'b0, out_tms_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  // The reset pulse count runs only while the TAP state is unknown
  a_rst_cnt_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rst_cnt_q != '0) |-> (tap_q == jtn_pkg::TAP_UNKNOWN))
    else $error("reset pulse count active with known TAP state");

  // A beat marked last leaves the TAP at the target state
  a_last_reaches_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && emit_last) |=> (tap_q == {1'b0, target_q}))
    else $error("last TMS beat does not land on the target");

  // A forget request marks the state unknown and starts no walk
  a_forget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i == jtn_pkg::OP_FORGET)
      |=> (tap_q == jtn_pkg::TAP_UNKNOWN && seq_q == SEQ_IDLE))
    else $error("forget did not clear the TAP state");

  // A walk never overwrites a beat that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |-> !step_en)
    else $error("walk stepped while output beat stalled");
`endif

endmodule

`default_nettype wire
